### hdl/motor_command_shaper_watchdog_macros.svh
// Assertion helpers used by the checker file.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef MOTOR_COMMAND_SHAPER_WATCHDOG_MACROS_SVH
`define MOTOR_COMMAND_SHAPER_WATCHDOG_MACROS_SVH

// Same-cycle implication
`define MCSW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MCSW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mcsw_pkg.sv
`timescale 1ns / 1ps

package mcsw_pkg;

  // Field and register widths
  localparam int unsigned PWM_BITS   = 12;
  localparam int unsigned CENTI_W    = 14;
  localparam int unsigned CMD_W      = 16;
  localparam int unsigned APPLIED_W  = 15;
  localparam int unsigned DUTY_W     = 12;
  localparam int unsigned IDLE_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CENTI_W-1:0] FULL_CENTI = CENTI_W'(10000);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = CFG_IDX_W'(2);

  // Reset values
  localparam logic [CENTI_W-1:0] DEADBAND_RST = CENTI_W'(0);
  localparam logic [CENTI_W-1:0] LIMIT_RST    = FULL_CENTI;
  localparam logic [IDLE_W-1:0]  TIMEOUT_RST  = IDLE_W'(500);

  // Item function and motor codes
  localparam logic FUNC_COMMAND = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;
  localparam logic MOTOR_RIGHT  = 1'b0;
  localparam logic MOTOR_LEFT   = 1'b1;

  // Duty scaling: floor(mag * (2^PWM_BITS - 1) / 10000).
  // The product is divided by 16 first (exact for floor), then by 625
  // through a reciprocal whose error stays below one step.
  localparam int unsigned PROD_W      = CENTI_W + PWM_BITS;
  localparam int unsigned QDIV_W      = PROD_W - 4;
  localparam int unsigned RECIP_SHIFT = QDIV_W + 10;
  localparam int unsigned RECIP_W     = QDIV_W + 1;
  localparam int unsigned SCALED_W    = QDIV_W + RECIP_W;
  localparam int unsigned QUO_W       = PWM_BITS + DUTY_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd624) / 64'd625);

  // Result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef struct packed {
    logic                        motor_id;
    logic                        bridge_in1;
    logic                        bridge_in2;
    logic [DUTY_W-1:0]           pwm_duty;
    logic signed [APPLIED_W-1:0] applied_centi;
    logic                        from_timeout;
    logic                        last_of_run;
  } result_t;

endpackage

### hdl/mcsw_intf.sv
`timescale 1ns / 1ps

// Input word channel
interface mcsw_item_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic                                 motor_select;
  logic signed [mcsw_pkg::CMD_W-1:0]    command_centi;

  modport source (output valid, func, motor_select, command_centi, input ready);
  modport sink   (input valid, func, motor_select, command_centi, output ready);
endinterface

// Result word channel
interface mcsw_result_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 motor_id;
  logic                                 bridge_in1;
  logic                                 bridge_in2;
  logic [mcsw_pkg::DUTY_W-1:0]          pwm_duty;
  logic signed [mcsw_pkg::APPLIED_W-1:0] applied_centi;
  logic                                 from_timeout;
  logic                                 last_of_run;

  modport source (output valid, motor_id, bridge_in1, bridge_in2, pwm_duty,
                  applied_centi, from_timeout, last_of_run, input ready);
  modport sink   (input valid, motor_id, bridge_in1, bridge_in2, pwm_duty,
                  applied_centi, from_timeout, last_of_run, output ready);
endinterface

### hdl/mcsw_shaper.sv
`timescale 1ns / 1ps

// Turn one motor command into bridge pins, duty and applied value.
module mcsw_shaper (
  input  logic                               motor_i,
  input  logic [mcsw_pkg::CMD_W-1:0]         command_i,
  input  logic [mcsw_pkg::CENTI_W-1:0]       deadband_i,
  input  logic [mcsw_pkg::CENTI_W-1:0]       limit_i,
  output mcsw_pkg::result_t                  result_o
);

  localparam int unsigned MAG_W = mcsw_pkg::CMD_W + 1;

  logic                                neg;
  logic [MAG_W-1:0]                    mag_raw;
  logic [MAG_W-1:0]                    mag_lift;
  logic [MAG_W-1:0]                    mag_clamp;
  logic [mcsw_pkg::CENTI_W-1:0]        mag;
  logic                                stop;
  logic [mcsw_pkg::PROD_W-1:0]         prod;
  logic [mcsw_pkg::QDIV_W-1:0]         qdiv;
  logic [mcsw_pkg::SCALED_W-1:0]       scaled;
  logic [mcsw_pkg::QUO_W-1:0]          quo;
  logic [mcsw_pkg::APPLIED_W-1:0]      mag_ext;

  // Take the magnitude; the most negative code gives 32768
  assign neg     = command_i[mcsw_pkg::CMD_W-1];
  assign mag_raw = neg ? ((MAG_W'(1) << mcsw_pkg::CMD_W) - MAG_W'(command_i))
                       : MAG_W'(command_i);

  // Raise to the deadband, then clamp to the limit; zero stays zero
  assign mag_lift  = (mag_raw < MAG_W'(deadband_i)) ? MAG_W'(deadband_i) : mag_raw;
  assign mag_clamp = (mag_lift > MAG_W'(limit_i)) ? MAG_W'(limit_i) : mag_lift;
  assign mag       = (mag_raw == '0) ? '0 : mcsw_pkg::CENTI_W'(mag_clamp);
  assign stop      = (mag == '0);

  // Scale to duty: mag * (2^PWM_BITS - 1), then divide by 10000
  assign prod   = (mcsw_pkg::PROD_W'(mag) << mcsw_pkg::PWM_BITS) - mcsw_pkg::PROD_W'(mag);
  assign qdiv   = prod[mcsw_pkg::PROD_W-1:4];
  assign scaled = mcsw_pkg::SCALED_W'(qdiv) * mcsw_pkg::SCALED_W'(mcsw_pkg::RECIP);
  assign quo    = mcsw_pkg::QUO_W'(scaled >> mcsw_pkg::RECIP_SHIFT);

  assign mag_ext = mcsw_pkg::APPLIED_W'(mag);

  // Pins: right motor forward is in1=0/in2=1, left is mirrored, reverse flips both
  always_comb begin
    result_o.motor_id      = motor_i;
    result_o.bridge_in1    = stop ? 1'b0 : (motor_i ^ neg);
    result_o.bridge_in2    = stop ? 1'b0 : ~(motor_i ^ neg);
    result_o.pwm_duty      = stop ? '0 : quo[mcsw_pkg::DUTY_W-1:0];
    result_o.applied_centi = $signed(neg ? (mcsw_pkg::APPLIED_W'(0) - mag_ext) : mag_ext);
    result_o.from_timeout  = 1'b0;
    result_o.last_of_run   = 1'b1;
  end

endmodule

### hdl/mcsw_result_fifo.sv
`timescale 1ns / 1ps

// Small result queue: takes up to two words per cycle, gives one.
module mcsw_result_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    push_cnt_i,
  input  mcsw_pkg::result_t             push0_i,
  input  mcsw_pkg::result_t             push1_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output mcsw_pkg::result_t             data_o,
  output logic                          room_o
);

  mcsw_pkg::result_t                    entries_q [mcsw_pkg::FIFO_DEPTH];
  logic [mcsw_pkg::FIFO_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [mcsw_pkg::FIFO_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [mcsw_pkg::FIFO_CNT_W-1:0]      count_q, count_d;
  logic [mcsw_pkg::FIFO_PTR_W-1:0]      wr_ptr_nxt;

  assign wr_ptr_nxt = wr_ptr_q + mcsw_pkg::FIFO_PTR_W'(1);

  // Write up to two words at the tail
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      entries_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      entries_q[wr_ptr_nxt] <= push1_i;
    end
  end

  // Advance pointers and fill count
  assign wr_ptr_d = wr_ptr_q + mcsw_pkg::FIFO_PTR_W'(push_cnt_i);
  assign rd_ptr_d = rd_ptr_q + mcsw_pkg::FIFO_PTR_W'(pop_i);
  assign count_d  = count_q + mcsw_pkg::FIFO_CNT_W'(push_cnt_i)
                    - mcsw_pkg::FIFO_CNT_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];
  // Room for a full two-word push regardless of this cycle's pop
  assign room_o  = (count_q <= mcsw_pkg::FIFO_CNT_W'(mcsw_pkg::FIFO_DEPTH - 2));

endmodule

### hdl/motor_command_shaper_watchdog.sv
`timescale 1ns / 1ps

// Two-motor H-bridge command shaper with a per-motor command watchdog. One input word
// is taken per clock: a command word gives one result word (pins, duty, applied value),
// a tick word gives zero, one or two watchdog stop words, left motor first. Each word
// lands in an input register, is processed once the result queue has room, and its
// results are written into a four-entry result queue that drives the output port; the
// output drains one word per cycle while the receiver is ready. The input stalls only
// while fewer than two queue entries are free, so with the output always ready the
// block sustains one input word per cycle, limited by the single-word output port
// when ticks fire both watchdogs. Configuration writes take effect on the next word
// processed; deadband and limit take the low 14 bits of the write data, and values
// above 10000 there are held at 10000.
module motor_command_shaper_watchdog (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mcsw_item_if.sink                       item_i,
  mcsw_result_if.source                   result_o,
  input  logic                            cfg_we_i,
  input  logic [mcsw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcsw_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  // Input register
  logic                             in_valid_q, in_valid_d;
  logic                             in_func_q;
  logic                             in_motor_q;
  logic [mcsw_pkg::CMD_W-1:0]       in_cmd_q;
  logic                             accept;
  logic                             fire;

  // Configuration and watchdog state
  logic [mcsw_pkg::CENTI_W-1:0]     deadband_q;
  logic [mcsw_pkg::CENTI_W-1:0]     limit_q;
  logic [mcsw_pkg::IDLE_W-1:0]      timeout_q;
  logic [mcsw_pkg::CENTI_W-1:0]     cfg_centi;
  logic [mcsw_pkg::IDLE_W-1:0]      left_idle_q, left_idle_d;
  logic [mcsw_pkg::IDLE_W-1:0]      right_idle_q, right_idle_d;
  logic [mcsw_pkg::IDLE_W-1:0]      left_inc, right_inc;
  logic                             left_expired, right_expired;

  // Result path
  mcsw_pkg::result_t                cmd_res;
  mcsw_pkg::result_t                stop_left, stop_right;
  mcsw_pkg::result_t                push0, push1;
  logic [1:0]                       push_cnt;
  logic                             fifo_room;
  logic                             fifo_valid;
  mcsw_pkg::result_t                fifo_data;

  // Input handshake: the register frees up as its word is processed
  assign fire         = in_valid_q & fifo_room;
  assign item_i.ready = ~in_valid_q | fire;
  assign accept       = item_i.valid & item_i.ready;
  assign in_valid_d   = accept | (in_valid_q & ~fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_func_q  <= item_i.func;
      in_motor_q <= item_i.motor_select;
      in_cmd_q   <= item_i.command_centi;
    end
  end

  // Configuration writes; hold centi registers at full scale
  assign cfg_centi = (cfg_wdata_i[mcsw_pkg::CENTI_W-1:0] > mcsw_pkg::FULL_CENTI)
                     ? mcsw_pkg::FULL_CENTI : cfg_wdata_i[mcsw_pkg::CENTI_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= mcsw_pkg::DEADBAND_RST;
      limit_q    <= mcsw_pkg::LIMIT_RST;
      timeout_q  <= mcsw_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mcsw_pkg::CFG_DEADBAND: deadband_q <= cfg_centi;
        mcsw_pkg::CFG_LIMIT:    limit_q    <= cfg_centi;
        mcsw_pkg::CFG_TIMEOUT:  timeout_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Command shaping
  mcsw_shaper u_shaper (
    .motor_i    (in_motor_q),
    .command_i  (in_cmd_q),
    .deadband_i (deadband_q),
    .limit_i    (limit_q),
    .result_o   (cmd_res)
  );

  // Watchdog: saturate idle counters on a tick and compare with the timeout
  assign left_inc      = (left_idle_q == '1) ? left_idle_q
                                             : left_idle_q + mcsw_pkg::IDLE_W'(1);
  assign right_inc     = (right_idle_q == '1) ? right_idle_q
                                              : right_idle_q + mcsw_pkg::IDLE_W'(1);
  assign left_expired  = (left_inc > timeout_q);
  assign right_expired = (right_inc > timeout_q);

  always_comb begin
    stop_left               = '0;
    stop_left.motor_id      = mcsw_pkg::MOTOR_LEFT;
    stop_left.from_timeout  = 1'b1;
    stop_left.last_of_run   = ~right_expired;
    stop_right              = '0;
    stop_right.motor_id     = mcsw_pkg::MOTOR_RIGHT;
    stop_right.from_timeout = 1'b1;
    stop_right.last_of_run  = 1'b1;
  end

  // Select words to push and next idle counts
  always_comb begin
    push0        = cmd_res;
    push1        = stop_right;
    push_cnt     = 2'd0;
    left_idle_d  = left_idle_q;
    right_idle_d = right_idle_q;
    if (fire) begin
      if (in_func_q == mcsw_pkg::FUNC_COMMAND) begin
        push_cnt = 2'd1;
        if (in_motor_q == mcsw_pkg::MOTOR_RIGHT) begin
          right_idle_d = '0;
        end else begin
          left_idle_d = '0;
        end
      end else begin
        push0        = left_expired ? stop_left : stop_right;
        push_cnt     = {1'b0, left_expired} + {1'b0, right_expired};
        left_idle_d  = left_expired ? '0 : left_inc;
        right_idle_d = right_expired ? '0 : right_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_idle_q  <= '0;
      right_idle_q <= '0;
    end else begin
      left_idle_q  <= left_idle_d;
      right_idle_q <= right_idle_d;
    end
  end

  // Result queue and output word
  mcsw_result_fifo u_result_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (push0),
    .push1_i    (push1),
    .pop_i      (result_o.valid & result_o.ready),
    .valid_o    (fifo_valid),
    .data_o     (fifo_data),
    .room_o     (fifo_room)
  );

  assign result_o.valid         = fifo_valid;
  assign result_o.motor_id      = fifo_data.motor_id;
  assign result_o.bridge_in1    = fifo_data.bridge_in1;
  assign result_o.bridge_in2    = fifo_data.bridge_in2;
  assign result_o.pwm_duty      = fifo_data.pwm_duty;
  assign result_o.applied_centi = fifo_data.applied_centi;
  assign result_o.from_timeout  = fifo_data.from_timeout;
  assign result_o.last_of_run   = fifo_data.last_of_run;

endmodule

### hdl/mcsw_checker.sv
`timescale 1ns / 1ps
`include "motor_command_shaper_watchdog_macros.svh"

// Port-level checks on the result channel.
module mcsw_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 res_valid_i,
  input logic                                 res_ready_i,
  input logic                                 motor_id_i,
  input logic                                 bridge_in1_i,
  input logic                                 bridge_in2_i,
  input logic [mcsw_pkg::DUTY_W-1:0]          pwm_duty_i,
  input logic signed [mcsw_pkg::APPLIED_W-1:0] applied_centi_i,
  input logic                                 from_timeout_i,
  input logic                                 last_of_run_i
);

  // Watchdog words are always a full stop
  `MCSW_ASSERT_IMP(a_timeout_is_stop, res_valid_i && from_timeout_i, !bridge_in1_i && !bridge_in2_i && pwm_duty_i == '0 && applied_centi_i == '0, "watchdog word is not a stop")

  // A command gives exactly one word, so it closes its run
  `MCSW_ASSERT_IMP(a_command_last, res_valid_i && !from_timeout_i, last_of_run_i, "command word not marked last")

  // A zero applied value drives both pins low with zero duty
  `MCSW_ASSERT_IMP(a_zero_stops, res_valid_i && applied_centi_i == '0, !bridge_in1_i && !bridge_in2_i && pwm_duty_i == '0, "zero command not stopped")

  // Pin direction follows motor side and sign of the applied value
  `MCSW_ASSERT_IMP(a_pin_direction, res_valid_i && applied_centi_i != '0, bridge_in1_i == (motor_id_i ^ applied_centi_i[mcsw_pkg::APPLIED_W-1]) && bridge_in2_i != bridge_in1_i, "bridge pins disagree with direction")

  // A stalled word holds
  `MCSW_ASSERT_NXT(a_stall_holds, res_valid_i && !res_ready_i, res_valid_i && $stable(motor_id_i) && $stable(pwm_duty_i) && $stable(applied_centi_i) && $stable(last_of_run_i), "stalled result word changed")

endmodule

bind motor_command_shaper_watchdog mcsw_checker u_mcsw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (result_o.valid),
  .res_ready_i     (result_o.ready),
  .motor_id_i      (result_o.motor_id),
  .bridge_in1_i    (result_o.bridge_in1),
  .bridge_in2_i    (result_o.bridge_in2),
  .pwm_duty_i      (result_o.pwm_duty),
  .applied_centi_i (result_o.applied_centi),
  .from_timeout_i  (result_o.from_timeout),
  .last_of_run_i   (result_o.last_of_run)
);

### bench/motor_command_shaper_watchdog_tb.sv
`timescale 1ns / 1ps

module motor_command_shaper_watchdog_tb;
  import mcsw_pkg::*;

  localparam int unsigned CYCLE_LIMIT       = 1_000_000;
  localparam int unsigned SETTLE_CYCLES     = 4;
  localparam int unsigned ITEMS_PER_SETTING = 85;
  localparam int unsigned LONG_HOLD_CYCLES  = 80;

  // Predicts bridge words from accepted input words and checks them in order
  class bridge_word_scoreboard;
    result_t            expected_words[$];
    logic [CENTI_W-1:0] deadband   = DEADBAND_RST;
    logic [CENTI_W-1:0] limit      = LIMIT_RST;
    logic [IDLE_W-1:0]  timeout    = TIMEOUT_RST;
    logic [IDLE_W-1:0]  right_idle = '0;
    logic [IDLE_W-1:0]  left_idle  = '0;
    int unsigned        errors     = 0;

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DEADBAND: deadband = data[CENTI_W-1:0];
        CFG_LIMIT:    limit    = data[CENTI_W-1:0];
        CFG_TIMEOUT:  timeout  = data[IDLE_W-1:0];
        default: ;
      endcase
    endfunction

    // Raise to deadband, clamp to limit, scale to duty, pick pin levels
    function result_t shape_command(logic motor, logic [CMD_W-1:0] raw);
      result_t     r;
      logic        neg;
      int unsigned mag;
      int unsigned floor_c;
      int unsigned ceil_c;
      neg     = raw[CMD_W-1];
      mag     = neg ? 32'h1_0000 - raw : raw;
      floor_c = (deadband > FULL_CENTI) ? FULL_CENTI : deadband;
      ceil_c  = (limit > FULL_CENTI) ? FULL_CENTI : limit;
      if (mag != 0) begin
        if (mag < floor_c) mag = floor_c;
        if (mag > ceil_c) mag = ceil_c;
      end
      r             = '0;
      r.motor_id    = motor;
      r.last_of_run = 1'b1;
      if (mag != 0) begin
        r.bridge_in1    = (motor == MOTOR_LEFT) ^ neg;
        r.bridge_in2    = (motor == MOTOR_RIGHT) ^ neg;
        r.pwm_duty      = DUTY_W'((64'(mag) * ((64'd1 << PWM_BITS) - 1)) / 64'(FULL_CENTI));
        r.applied_centi = neg ? APPLIED_W'(32'h8000 - mag) : APPLIED_W'(mag);
      end
      return r;
    endfunction

    function result_t watchdog_stop(logic motor, logic last);
      result_t r;
      r              = '0;
      r.motor_id     = motor;
      r.from_timeout = 1'b1;
      r.last_of_run  = last;
      return r;
    endfunction

    function void note_input(logic func, logic motor, logic [CMD_W-1:0] cmd);
      logic fire_left;
      logic fire_right;
      if (func == FUNC_COMMAND) begin
        expected_words.push_back(shape_command(motor, cmd));
        if (motor == MOTOR_RIGHT) right_idle = '0;
        else left_idle = '0;
        return;
      end
      // Advance both idle counters with saturation, left motor checked first
      if (left_idle != '1) left_idle++;
      if (right_idle != '1) right_idle++;
      fire_left  = left_idle > timeout;
      fire_right = right_idle > timeout;
      if (fire_left) begin
        expected_words.push_back(watchdog_stop(MOTOR_LEFT, !fire_right));
        left_idle = '0;
      end
      if (fire_right) begin
        expected_words.push_back(watchdog_stop(MOTOR_RIGHT, 1'b1));
        right_idle = '0;
      end
    endfunction

    function void check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        $error("bridge word with no expectation: motor_id %0d, duty %0d, applied %0d",
               got.motor_id, got.pwm_duty, got.applied_centi);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      check_field("motor_id", want.motor_id, got.motor_id);
      check_field("bridge_in1", want.bridge_in1, got.bridge_in1);
      check_field("bridge_in2", want.bridge_in2, got.bridge_in2);
      check_field("pwm_duty", want.pwm_duty, got.pwm_duty);
      check_field("applied_centi", want.applied_centi, got.applied_centi);
      check_field("from_timeout", want.from_timeout, got.from_timeout);
      check_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  int unsigned rx_hold_cycles = 0;
  int unsigned cycle_count    = 0;

  bridge_word_scoreboard sb;

  mcsw_item_if   item_if ();
  mcsw_result_if res_if ();

  motor_command_shaper_watchdog dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if),
    .result_o    (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // End the run if it hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("motor_command_shaper_watchdog_tb failed");
    $finish;
  end

  // Result sink: random stalls, long hold on request, check every accepted word
  initial begin : result_sink
    result_t got;
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles != 0) begin
        res_if.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got.motor_id      = res_if.motor_id;
        got.bridge_in1    = res_if.bridge_in1;
        got.bridge_in2    = res_if.bridge_in2;
        got.pwm_duty      = res_if.pwm_duty;
        got.applied_centi = res_if.applied_centi;
        got.from_timeout  = res_if.from_timeout;
        got.last_of_run   = res_if.last_of_run;
        sb.check_result(got);
      end
    end
  end

  // Offer one word, idling first at random, and hold it until accepted
  task automatic send_word(input logic func, input logic motor, input logic [CMD_W-1:0] cmd);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    item_if.valid         <= 1'b1;
    item_if.func          <= func;
    item_if.motor_select  <= motor;
    item_if.command_centi <= cmd;
    do @(posedge clk_i); while (!item_if.ready);
    sb.note_input(func, motor, cmd);
  endtask

  task automatic send_command(input logic motor, input logic [CMD_W-1:0] cmd);
    send_word(FUNC_COMMAND, motor, cmd);
  endtask

  // Ignored fields carry noise on a tick
  task automatic send_tick();
    send_word(FUNC_TICK, 1'($urandom_range(1)), CMD_W'($urandom));
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Drain, then give a silent tick time to leave the pipeline
  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic program_setting(input logic [CFG_DATA_W-1:0] deadband,
                                 input logic [CFG_DATA_W-1:0] limit,
                                 input logic [CFG_DATA_W-1:0] timeout);
    wait_idle();
    program_register(CFG_DEADBAND, deadband);
    program_register(CFG_LIMIT, limit);
    program_register(CFG_TIMEOUT, timeout);
  endtask

  // Pick a setting with weight on the extremes and on saturating values
  task automatic program_random_setting();
    logic [CFG_DATA_W-1:0] deadband;
    logic [CFG_DATA_W-1:0] limit;
    logic [CFG_DATA_W-1:0] timeout;
    case ($urandom_range(4))
      0:       deadband = '0;
      1:       deadband = CFG_DATA_W'($urandom_range(16383, 10000));
      2:       deadband = CFG_DATA_W'($urandom_range(1000));
      3:       deadband = CFG_DATA_W'($urandom_range(10000));
      default: deadband = CFG_DATA_W'($urandom);
    endcase
    case ($urandom_range(4))
      0:       limit = CFG_DATA_W'(10000);
      1:       limit = '0;
      2:       limit = CFG_DATA_W'($urandom_range(10000));
      3:       limit = CFG_DATA_W'($urandom_range(10000, 2000));
      default: limit = CFG_DATA_W'($urandom);
    endcase
    case ($urandom_range(5))
      0:       timeout = '0;
      1:       timeout = CFG_DATA_W'(1);
      2:       timeout = CFG_DATA_W'($urandom_range(8, 2));
      3:       timeout = CFG_DATA_W'($urandom_range(40));
      4:       timeout = CFG_DATA_W'($urandom_range(120, 10));
      default: timeout = '1;
    endcase
    program_setting(deadband, limit, timeout);
  endtask

  // Mix of edge values, in-range, small and raw 16-bit commands
  function automatic logic [CMD_W-1:0] rand_command();
    logic [CMD_W-1:0] v;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(5))
          0:       v = 16'h8000;
          1:       v = 16'h7FFF;
          2:       v = 16'd1;
          3:       v = 16'd10000;
          4:       v = 16'd10001;
          default: v = 16'd9999;
        endcase
      end
      1, 2, 3: v = CMD_W'($urandom_range(12000));
      4, 5:    v = CMD_W'($urandom_range(600));
      6:       v = CMD_W'($urandom);
      default: v = '0;
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  initial begin
    rst_ni                = 1'b0;
    item_if.valid         = 1'b0;
    item_if.func          = FUNC_COMMAND;
    item_if.motor_select  = MOTOR_RIGHT;
    item_if.command_centi = '0;
    cfg_we                = 1'b0;
    cfg_idx               = CFG_DEADBAND;
    cfg_wdata             = '0;
    sb                    = new;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: full scale on both motors, most positive and most negative codes, stop, tiny magnitude
    send_command(MOTOR_RIGHT, 16'd10000);
    send_command(MOTOR_LEFT, 16'd10000);
    send_command(MOTOR_RIGHT, 16'h8000);
    send_command(MOTOR_LEFT, 16'h7FFF);
    send_command(MOTOR_RIGHT, 16'd0);
    send_command(MOTOR_LEFT, 16'hFFFF);
    send_tick();

    // Registers above full scale saturate; zero timeout stops both on every tick
    program_setting(16'hFFFF, 16'hFFFF, 16'd0);
    send_command(MOTOR_RIGHT, 16'd1);
    send_tick();

    // Deadband raises small commands, limit clips large ones
    program_setting(16'd500, 16'd8000, 16'd1);
    send_command(MOTOR_RIGHT, 16'd1);
    send_command(MOTOR_LEFT, -16'sd9000);
    send_command(MOTOR_RIGHT, -16'sd200);
    send_tick();
    send_tick();
    send_command(MOTOR_LEFT, 16'd5);
    send_tick();
    send_tick();

    // Zero limit turns every command into a stop
    program_setting(16'd0, 16'd0, 16'd2);
    send_command(MOTOR_RIGHT, 16'd5);
    send_command(MOTOR_LEFT, 16'h8000);
    send_tick();
    send_tick();
    send_tick();

    // Deadband above limit: limit wins
    program_setting(16'd10000, 16'd1, 16'd3);
    send_command(MOTOR_RIGHT, 16'd7);
    send_command(MOTOR_LEFT, 16'hFFFF);

    // Random words under three stall patterns and several settings each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct  = 10;
          rx_stall_pct = 72;
        end
        1: begin
          tx_idle_pct  = 72;
          rx_stall_pct = 10;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 6; blk++) begin
        program_random_setting();
        // Hold the sink off so the result queue fills and the input stalls
        if (phase == 2 && blk == 0) rx_hold_cycles = LONG_HOLD_CYCLES;
        for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
          if (phase == 0 && blk == 2 && i == 40) wait_results();
          if ($urandom_range(99) < 55) send_tick();
          else send_command(1'($urandom_range(1)), rand_command());
        end
      end
    end

    wait_results();
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("motor_command_shaper_watchdog_tb passed");
    end else begin
      $display("motor_command_shaper_watchdog_tb failed");
    end
    $finish;
  end

endmodule

### motor_command_shaper_watchdog.f
+incdir+hdl
hdl/mcsw_pkg.sv
hdl/mcsw_intf.sv
hdl/mcsw_shaper.sv
hdl/mcsw_result_fifo.sv
hdl/motor_command_shaper_watchdog.sv
hdl/mcsw_checker.sv
bench/motor_command_shaper_watchdog_tb.sv
